// ===== rtl/byte_stream_diff_run_tracker_assert.svh =====
// assertion helpers for the run tracker, sampled on clk_i, off while rst_ni is low
`ifndef BYTE_STREAM_DIFF_RUN_TRACKER_ASSERT_SVH
`define BYTE_STREAM_DIFF_RUN_TRACKER_ASSERT_SVH

// same-cycle implication
`define BSDRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("run tracker check failed");

// next-cycle implication
`define BSDRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("run tracker check failed");

`endif

// ===== rtl/bsdrt_pkg.sv =====
package bsdrt_pkg;

  localparam int unsigned POS_WIDTH_DEF = 48;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned OFF_W         = 32;
  localparam int unsigned OUT_POS_W     = 48;
  localparam int unsigned OUT_LEN_W     = 49;
  localparam int unsigned IN_DATA_W     = 16;
  localparam int unsigned OUT_DATA_W    = 408;

  localparam logic [CFG_W-1:0]     BLOCK_SIZE_RST = 32'd65536;
  localparam logic [CFG_W-1:0]     BIG_THRESH_RST = 32'd32768;
  localparam logic [OUT_LEN_W-1:0] TOTAL_MAX      = '1;

  typedef enum logic [0:0] {
    REG_BLOCK_SIZE    = 1'b0,
    REG_BIG_THRESHOLD = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_MATCH  = 1'b0,
    KIND_DIFFER = 1'b1
  } run_kind_e;

  // first member is the top bits of tdata
  typedef struct packed {
    logic [3:0]           pad;
    logic [OUT_LEN_W-1:0] total_bad_groups;
    logic [OUT_LEN_W-1:0] total_bad_bytes;
    logic                 is_big;
    logic [OFF_W-1:0]     end_in_block;
    logic [OUT_POS_W-1:0] end_block;
    logic [OFF_W-1:0]     start_in_block;
    logic [OUT_POS_W-1:0] start_block;
    logic [OUT_LEN_W-1:0] run_length;
    logic [OUT_POS_W-1:0] run_end;
    logic [OUT_POS_W-1:0] run_start;
  } out_data_t;

  typedef struct packed {
    run_kind_e kind;
    out_data_t data;
    logic      last;
  } result_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

// ===== rtl/byte_stream_diff_run_tracker.sv =====
// flow: a byte pair is registered at acceptance, classified in the next cycle and its
// runs are written to a four-word result queue once that queue has two free slots
// throughput: one pair per cycle while the result queue has two free slots; words leave the
// queue at one per cycle while m_axis_tready is high; a pair closing two runs gives two words
// reset: rst_ni low clears run state, totals and the queue; the block length and big threshold
// registers return to 65536 and 32768; after a final pair the run state and totals clear again
`include "byte_stream_diff_run_tracker_assert.svh"

module byte_stream_diff_run_tracker #(
  parameter int unsigned POS_WIDTH = bsdrt_pkg::POS_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  bsdrt_pkg::reg_idx_e                 cfg_idx_i,
  input  logic [bsdrt_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bsdrt_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // byte_a, byte_b
  input  logic                                s_axis_tlast,  // is_final
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // run_start, run_end, run_length, start_block, start_in_block, end_block,
  // end_in_block, is_big, total_bad_bytes, total_bad_groups, zero pad
  output logic [bsdrt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,  // run_kind
  output logic                                m_axis_tlast   // last_of_burst
);
  import bsdrt_pkg::*;

  localparam int unsigned LEN_W = (POS_WIDTH < 64) ? POS_WIDTH + 1 : 64;
  localparam int unsigned SUM_W = ((LEN_W > OUT_LEN_W) ? LEN_W : OUT_LEN_W) + 1;
  localparam int unsigned CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  typedef struct packed {
    logic [POS_WIDTH-1:0] blk;
    logic [OFF_W-1:0]     off;
  } coord_t;

  typedef enum logic [1:0] {SEL_CUR, SEL_PREV, SEL_PREV2} end_sel_e;
  typedef enum logic [1:0] {NB_KEEP, NB_CUR, NB_PREV} begin_sel_e;

  // configuration
  logic [CFG_W-1:0] blk_len_q, big_thresh_q;

  // input register
  logic       in_vld_q;
  logic [7:0] in_a_q, in_b_q;
  logic       in_fin_q;

  // run state
  logic                 in_differ_q, in_differ_d;
  logic                 pending_q, pending_d;
  logic [POS_WIDTH-1:0] pos_q, rb_pos_q;
  coord_t               cur_q, prior0_q, prior1_q, rb_crd_q;
  logic [OUT_LEN_W-1:0] err_bytes_q, bad_groups_q;

  logic                 go, room, eq;
  logic [POS_WIDTH-1:0] pos_m1, pos_m2;
  logic                 e0_en, e1_en;
  run_kind_e            e0_kind, e1_kind;
  end_sel_e             e0_sel;
  begin_sel_e           nb_sel;
  logic [POS_WIDTH-1:0] e0_end_pos, nb_pos;
  coord_t               e0_end_crd, nb_crd, cur_next;
  logic [POS_WIDTH-1:0] span0, span1;
  logic [LEN_W-1:0]     len0, len1, dlen;
  logic                 differ_add;
  logic [SUM_W-1:0]     byte_sum;
  logic [OUT_LEN_W-1:0] bytes_new, groups_new, bytes_tot, groups_tot;
  logic                 blk_wrap;
  push_t                push;
  result_t              res0, res1, out_word;

  function automatic result_t make_result(
    input run_kind_e            kind,
    input logic [POS_WIDTH-1:0] s_pos,
    input coord_t               s_crd,
    input logic [POS_WIDTH-1:0] e_pos,
    input coord_t               e_crd,
    input logic [LEN_W-1:0]     len,
    input logic [CFG_W-1:0]     thresh,
    input logic [OUT_LEN_W-1:0] bytes,
    input logic [OUT_LEN_W-1:0] groups,
    input logic                 last
  );
    result_t r;
    r.kind                  = kind;
    r.data.pad              = '0;
    r.data.run_start        = OUT_POS_W'(s_pos);
    r.data.run_end          = OUT_POS_W'(e_pos);
    r.data.run_length       = OUT_LEN_W'(len);
    r.data.start_block      = OUT_POS_W'(s_crd.blk);
    r.data.start_in_block   = s_crd.off;
    r.data.end_block        = OUT_POS_W'(e_crd.blk);
    r.data.end_in_block     = e_crd.off;
    r.data.is_big           = (kind == KIND_MATCH) && (CMP_W'(len) >= CMP_W'(thresh));
    r.data.total_bad_bytes  = bytes;
    r.data.total_bad_groups = groups;
    r.last                  = last;
    return r;
  endfunction

  assign go            = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || go;
  assign eq            = (in_a_q == in_b_q);
  assign pos_m1        = pos_q - POS_WIDTH'(1);
  assign pos_m2        = pos_q - POS_WIDTH'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len_q    <= BLOCK_SIZE_RST;
      big_thresh_q <= BIG_THRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLOCK_SIZE:    blk_len_q    <= cfg_wdata_i;
        REG_BIG_THRESHOLD: big_thresh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_a_q   <= s_axis_tdata[7:0];
      in_b_q   <= s_axis_tdata[15:8];
      in_fin_q <= s_axis_tlast;
    end
  end

  // run classification; at most one of the two runs closed per pair is a differ run
  always_comb begin
    e0_en       = 1'b0;
    e0_kind     = KIND_MATCH;
    e0_sel      = SEL_CUR;
    e1_en       = 1'b0;
    e1_kind     = KIND_MATCH;
    nb_sel      = NB_KEEP;
    in_differ_d = in_differ_q;
    pending_d   = pending_q;
    if (!in_differ_q) begin
      if (!eq) begin
        // an empty match run is dropped
        if (pos_q != rb_pos_q) begin
          e0_en   = 1'b1;
          e0_kind = KIND_MATCH;
          e0_sel  = SEL_PREV;
        end
        nb_sel      = NB_CUR;
        in_differ_d = 1'b1;
        if (in_fin_q) begin
          e1_en   = 1'b1;
          e1_kind = KIND_DIFFER;
        end
      end else if (in_fin_q) begin
        e0_en   = 1'b1;
        e0_kind = KIND_MATCH;
        e0_sel  = SEL_CUR;
      end
    end else if (pending_q) begin
      pending_d = 1'b0;
      if (eq) begin
        // two matches in a row: the differ run ends before the pending byte
        e0_en       = 1'b1;
        e0_kind     = KIND_DIFFER;
        e0_sel      = SEL_PREV2;
        nb_sel      = NB_PREV;
        in_differ_d = 1'b0;
        if (in_fin_q) begin
          e1_en   = 1'b1;
          e1_kind = KIND_MATCH;
        end
      end else if (in_fin_q) begin
        e0_en   = 1'b1;
        e0_kind = KIND_DIFFER;
        e0_sel  = SEL_CUR;
      end
    end else begin
      if (eq) begin
        if (in_fin_q) begin
          e0_en   = 1'b1;
          e0_kind = KIND_DIFFER;
          e0_sel  = SEL_PREV;
          nb_sel  = NB_CUR;
          e1_en   = 1'b1;
          e1_kind = KIND_MATCH;
        end else begin
          pending_d = 1'b1;
        end
      end else if (in_fin_q) begin
        e0_en   = 1'b1;
        e0_kind = KIND_DIFFER;
        e0_sel  = SEL_CUR;
      end
    end
  end

  always_comb begin
    case (e0_sel)
      SEL_PREV: begin
        e0_end_pos = pos_m1;
        e0_end_crd = prior0_q;
      end
      SEL_PREV2: begin
        e0_end_pos = pos_m2;
        e0_end_crd = prior1_q;
      end
      default: begin
        e0_end_pos = pos_q;
        e0_end_crd = cur_q;
      end
    endcase
    case (nb_sel)
      NB_CUR: begin
        nb_pos = pos_q;
        nb_crd = cur_q;
      end
      NB_PREV: begin
        nb_pos = pos_m1;
        nb_crd = prior0_q;
      end
      default: begin
        nb_pos = rb_pos_q;
        nb_crd = rb_crd_q;
      end
    endcase
  end

  // spans wrap at the position width before the length gets its extra bit
  always_comb begin
    span0      = e0_end_pos - rb_pos_q;
    span1      = pos_q - nb_pos;
    len0       = LEN_W'(span0) + LEN_W'(1);
    len1       = LEN_W'(span1) + LEN_W'(1);
    differ_add = (e0_en && (e0_kind == KIND_DIFFER)) || (e1_en && (e1_kind == KIND_DIFFER));
    dlen       = (e0_en && (e0_kind == KIND_DIFFER)) ? len0 : len1;
    byte_sum   = SUM_W'(err_bytes_q) + SUM_W'(dlen);
    bytes_new  = (byte_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : OUT_LEN_W'(byte_sum);
    groups_new = (bad_groups_q == TOTAL_MAX) ? TOTAL_MAX : bad_groups_q + 1'b1;
    bytes_tot  = differ_add ? bytes_new : err_bytes_q;
    groups_tot = differ_add ? groups_new : bad_groups_q;
  end

  always_comb begin
    res0 = make_result(e0_kind, rb_pos_q, rb_crd_q, e0_end_pos, e0_end_crd, len0,
                       big_thresh_q,
                       (e0_kind == KIND_DIFFER) ? bytes_tot : err_bytes_q,
                       (e0_kind == KIND_DIFFER) ? groups_tot : bad_groups_q,
                       !e1_en);
    res1 = make_result(e1_kind, nb_pos, nb_crd, pos_q, cur_q, len1, big_thresh_q,
                       bytes_tot, groups_tot, 1'b1);
    push.push0 = go && e0_en;
    push.push1 = go && e1_en;
  end

  // block counters wrap at the block length, a zero length acts as one
  always_comb begin
    blk_wrap = (blk_len_q == '0) ||
               ({1'b0, cur_q.off} + 33'd1 >= {1'b0, blk_len_q});
    if (blk_wrap) begin
      cur_next.off = '0;
      cur_next.blk = cur_q.blk + 1'b1;
    end else begin
      cur_next.off = cur_q.off + 1'b1;
      cur_next.blk = cur_q.blk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_differ_q  <= 1'b0;
      pending_q    <= 1'b0;
      pos_q        <= '0;
      cur_q        <= '0;
      prior0_q     <= '0;
      prior1_q     <= '0;
      rb_pos_q     <= '0;
      rb_crd_q     <= '0;
      err_bytes_q  <= '0;
      bad_groups_q <= '0;
    end else if (go) begin
      if (in_fin_q) begin
        in_differ_q  <= 1'b0;
        pending_q    <= 1'b0;
        pos_q        <= '0;
        cur_q        <= '0;
        prior0_q     <= '0;
        prior1_q     <= '0;
        rb_pos_q     <= '0;
        rb_crd_q     <= '0;
        err_bytes_q  <= '0;
        bad_groups_q <= '0;
      end else begin
        in_differ_q  <= in_differ_d;
        pending_q    <= pending_d;
        pos_q        <= pos_q + 1'b1;
        cur_q        <= cur_next;
        prior0_q     <= cur_q;
        prior1_q     <= prior0_q;
        rb_pos_q     <= nb_pos;
        rb_crd_q     <= nb_crd;
        err_bytes_q  <= bytes_tot;
        bad_groups_q <= groups_tot;
      end
    end
  end

  bsdrt_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .data0_i   (res0),
    .data1_i   (res1),
    .room_o    (room),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (out_word)
  );

  assign m_axis_tdata = out_word.data;
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.last;

  `BSDRT_ASSERT_IMP(a_pending_only_in_differ, !in_differ_q, !pending_q)
  `BSDRT_ASSERT_NXT(a_final_clears_position, go && in_fin_q, pos_q == '0 && !in_differ_q)
  `BSDRT_ASSERT_NXT(a_groups_monotonic, go && !in_fin_q, bad_groups_q >= $past(bad_groups_q))

endmodule

// ===== rtl/bsdrt_out_fifo.sv =====
module bsdrt_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsdrt_pkg::push_t   push_i,
  input  bsdrt_pkg::result_t data0_i,
  input  bsdrt_pkg::result_t data1_i,
  output logic               room_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output bsdrt_pkg::result_t m_data_o
);
  import bsdrt_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  result_t           mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d, wr_second;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pop;

  assign pop       = m_valid_o && m_ready_i;
  assign m_valid_o = (cnt_q != '0);
  assign m_data_o  = mem_q[rd_q];
  // two free slots needed, an item may give two words
  assign room_o    = (cnt_q <= CNT_W'(DEPTH - 2));
  assign wr_second = push_i.push0 ? wr_q + 1'b1 : wr_q;

  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.push0) + PTR_W'(push_i.push1);
    rd_d  = rd_q + PTR_W'(pop);
    cnt_d = cnt_q + CNT_W'(push_i.push0) + CNT_W'(push_i.push1) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push_i.push1) begin
      mem_q[wr_second] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsdrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // predicts the closed runs of the tracker and checks the words that come out
  class run_ledger;
    logic [CFG_W-1:0]     blk_len;
    logic [CFG_W-1:0]     big_threshold;
    bit                   in_differ;
    bit                   pending_match;
    logic [OUT_POS_W-1:0] pos;
    logic [OUT_POS_W-1:0] cur_blk;
    logic [OFF_W-1:0]     cur_off;
    logic [OUT_POS_W-1:0] prev_blk [2];
    logic [OFF_W-1:0]     prev_off [2];
    logic [OUT_POS_W-1:0] begin_pos;
    logic [OUT_POS_W-1:0] begin_blk;
    logic [OFF_W-1:0]     begin_off;
    logic [OUT_LEN_W-1:0] err_bytes;
    logic [OUT_LEN_W-1:0] bad_runs;
    result_t              runs_due [$];
    int unsigned          mismatches;

    function new();
      blk_len       = BLOCK_SIZE_RST;
      big_threshold = BIG_THRESH_RST;
      mismatches    = 0;
      clear_runs();
    endfunction

    function void clear_runs();
      in_differ     = 1'b0;
      pending_match = 1'b0;
      pos           = '0;
      cur_blk       = '0;
      cur_off       = '0;
      prev_blk[0]   = '0;
      prev_blk[1]   = '0;
      prev_off[0]   = '0;
      prev_off[1]   = '0;
      begin_pos     = '0;
      begin_blk     = '0;
      begin_off     = '0;
      err_bytes     = '0;
      bad_runs      = '0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] value);
      if (idx == REG_BLOCK_SIZE) begin
        blk_len = value;
      end else begin
        big_threshold = value;
      end
    endfunction

    function logic [OUT_LEN_W-1:0] sat_add(logic [OUT_LEN_W-1:0] a, logic [OUT_LEN_W-1:0] b);
      logic [OUT_LEN_W:0] s;
      s = a + b;
      return s[OUT_LEN_W] ? TOTAL_MAX : s[OUT_LEN_W-1:0];
    endfunction

    function void start_run(logic [OUT_POS_W-1:0] p, logic [OUT_POS_W-1:0] blk,
                            logic [OFF_W-1:0] off);
      begin_pos = p;
      begin_blk = blk;
      begin_off = off;
    endfunction

    function result_t close_run(run_kind_e kind, logic [OUT_POS_W-1:0] end_pos,
                                logic [OUT_POS_W-1:0] end_blk, logic [OFF_W-1:0] end_off);
      result_t              r;
      logic [OUT_POS_W-1:0] span;
      logic [OUT_LEN_W-1:0] len;
      span = end_pos - begin_pos;
      len  = span + 1;
      if (kind == KIND_DIFFER) begin
        err_bytes = sat_add(err_bytes, len);
        bad_runs  = sat_add(bad_runs, OUT_LEN_W'(1));
      end
      r                     = '0;
      r.kind                = kind;
      r.data.run_start      = begin_pos;
      r.data.run_end        = end_pos;
      r.data.run_length     = len;
      r.data.start_block    = begin_blk;
      r.data.start_in_block = begin_off;
      r.data.end_block      = end_blk;
      r.data.end_in_block   = end_off;
      r.data.is_big         = (kind == KIND_MATCH) && (len >= big_threshold);
      r.data.total_bad_bytes  = err_bytes;
      r.data.total_bad_groups = bad_runs;
      return r;
    endfunction

    // one accepted byte pair: queue the runs it closes, then move to the next position
    function void take_pair(logic [7:0] byte_a, logic [7:0] byte_b, logic final_pair);
      result_t              closed [2];
      int                   n;
      logic                 eq;
      logic [OUT_POS_W-1:0] p;
      eq = (byte_a == byte_b);
      p  = pos;
      n  = 0;
      if (!in_differ) begin
        if (!eq) begin
          // a match run with no bytes is dropped
          if (p != begin_pos) begin
            closed[n] = close_run(KIND_MATCH, p - 1'b1, prev_blk[0], prev_off[0]);
            n++;
          end
          start_run(p, cur_blk, cur_off);
          in_differ = 1'b1;
          if (final_pair) begin
            closed[n] = close_run(KIND_DIFFER, p, cur_blk, cur_off);
            n++;
          end
        end else if (final_pair) begin
          closed[n] = close_run(KIND_MATCH, p, cur_blk, cur_off);
          n++;
        end
      end else if (pending_match) begin
        pending_match = 1'b0;
        if (eq) begin
          // second match in a row: the differ run ends before the held byte
          closed[n] = close_run(KIND_DIFFER, p - 2'd2, prev_blk[1], prev_off[1]);
          n++;
          start_run(p - 1'b1, prev_blk[0], prev_off[0]);
          in_differ = 1'b0;
          if (final_pair) begin
            closed[n] = close_run(KIND_MATCH, p, cur_blk, cur_off);
            n++;
          end
        end else if (final_pair) begin
          closed[n] = close_run(KIND_DIFFER, p, cur_blk, cur_off);
          n++;
        end
      end else begin
        if (eq) begin
          if (final_pair) begin
            closed[n] = close_run(KIND_DIFFER, p - 1'b1, prev_blk[0], prev_off[0]);
            n++;
            start_run(p, cur_blk, cur_off);
            closed[n] = close_run(KIND_MATCH, p, cur_blk, cur_off);
            n++;
          end else begin
            pending_match = 1'b1;
          end
        end else if (final_pair) begin
          closed[n] = close_run(KIND_DIFFER, p, cur_blk, cur_off);
          n++;
        end
      end
      if (n > 0) begin
        closed[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        runs_due.push_back(closed[i]);
      end
      if (final_pair) begin
        clear_runs();
      end else begin
        prev_blk[1] = prev_blk[0];
        prev_off[1] = prev_off[0];
        prev_blk[0] = cur_blk;
        prev_off[0] = cur_off;
        if (blk_len == 0 || {1'b0, cur_off} + 1 >= {1'b0, blk_len}) begin
          cur_off = '0;
          cur_blk = cur_blk + 1'b1;
        end else begin
          cur_off = cur_off + 1'b1;
        end
        pos = pos + 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_run(logic kind, logic [OUT_DATA_W-1:0] data, logic last);
      out_data_t got;
      result_t   want;
      got = data;
      if (runs_due.size() == 0) begin
        $error("run word with nothing expected: run_start 0x%0h", got.run_start);
        mismatches++;
        return;
      end
      want = runs_due.pop_front();
      compare_field("run_kind", want.kind, kind);
      compare_field("run_start", want.data.run_start, got.run_start);
      compare_field("run_end", want.data.run_end, got.run_end);
      compare_field("run_length", want.data.run_length, got.run_length);
      compare_field("start_block", want.data.start_block, got.start_block);
      compare_field("start_in_block", want.data.start_in_block, got.start_in_block);
      compare_field("end_block", want.data.end_block, got.end_block);
      compare_field("end_in_block", want.data.end_in_block, got.end_in_block);
      compare_field("is_big", want.data.is_big, got.is_big);
      compare_field("total_bad_bytes", want.data.total_bad_bytes, got.total_bad_bytes);
      compare_field("total_bad_groups", want.data.total_bad_groups, got.total_bad_groups);
      compare_field("pad", 64'd0, got.pad);
      compare_field("last_of_burst", want.last, last);
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  reg_idx_e              cfg_idx_i     = REG_BLOCK_SIZE;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // byte_a, byte_b
  logic                  s_axis_tlast  = 1'b0;  // is_final
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // run fields from run_start up, zero pad on top
  logic                  m_axis_tuser;  // run_kind
  logic                  m_axis_tlast;  // last_of_burst

  run_ledger   ledger;
  int unsigned cycle_cnt   = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_mode     = 0;
  int unsigned rx_left     = 0;
  int unsigned rx_tick     = 0;

  byte_stream_diff_run_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver: switches between always ready, coin flips, one in four and long stalls
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= (rx_tick % 4 == 0);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 15) < 2);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      ledger.check_run(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // offers one word in the current burst, opening a new burst when needed, mostly after a gap
  task automatic send_pair(logic [7:0] byte_a, logic [7:0] byte_b, logic final_pair);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        idle($urandom_range(1, 6));
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {byte_b, byte_a};
    s_axis_tlast  <= final_pair;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    ledger.take_pair(byte_a, byte_b, final_pair);
  endtask

  task automatic wait_drained();
    idle(1);
    while (ledger.runs_due.size() != 0) begin
      @(posedge clk_i);
    end
    // a pair that closes nothing may still be in flight
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ledger.set_reg(idx, value);
  endtask

  // compare ranges made of alternating match and differ stretches, with some noise
  task automatic random_pairs(int unsigned n_items);
    int unsigned sent;
    int unsigned range_left;
    int unsigned stretch_left;
    bit          match_stretch;
    logic [7:0]  a;
    logic [7:0]  b;
    bit          eq;
    sent          = 0;
    stretch_left  = 0;
    match_stretch = 1'($urandom_range(0, 1));
    range_left    = $urandom_range(1, 80);
    while (sent < n_items) begin
      if (stretch_left == 0) begin
        match_stretch = !match_stretch;
        stretch_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(1, 4);
      end
      if (match_stretch) begin
        eq = 1'b1;
      end else begin
        // isolated matches inside a differ stretch exercise the lookahead
        eq = ($urandom_range(0, 4) == 0);
      end
      a = 8'($urandom);
      b = eq ? a : a ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 15) == 0) begin
        b = 8'($urandom);
      end
      send_pair(a, b, range_left == 1);
      sent++;
      stretch_left--;
      range_left--;
      if (range_left == 0) begin
        range_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 80);
      end
      if (sent == n_items / 2) begin
        wait_drained();
      end
    end
  endtask

  task automatic run_setting(logic [CFG_W-1:0] blk, logic [CFG_W-1:0] thresh);
    write_reg(REG_BLOCK_SIZE, blk);
    write_reg(REG_BIG_THRESHOLD, thresh);
    random_pairs(229);
    wait_drained();
  endtask

  initial begin
    ledger = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // lone final match, lone final differ
    send_pair(8'h00, 8'h00, 1'b1);
    send_pair(8'hFF, 8'h00, 1'b1);
    // differ at position zero, then a held match that is confirmed
    send_pair(8'h55, 8'hAA, 1'b0);
    send_pair(8'h12, 8'h12, 1'b0);
    send_pair(8'h34, 8'h34, 1'b0);
    send_pair(8'h00, 8'hFF, 1'b0);
    // held match that turns back into differ
    send_pair(8'h77, 8'h77, 1'b0);
    send_pair(8'h01, 8'h02, 1'b0);
    // held match confirmed by the final pair: two runs at once
    send_pair(8'h80, 8'h80, 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b1);
    // final match right after a differ byte
    send_pair(8'h09, 8'h08, 1'b0);
    send_pair(8'h10, 8'h10, 1'b1);
    // final differ after a held match
    send_pair(8'h01, 8'h01, 1'b0);
    send_pair(8'hC3, 8'h3C, 1'b0);
    send_pair(8'h5A, 8'h5A, 1'b0);
    send_pair(8'h00, 8'h01, 1'b1);
    // match run closed by a final differ
    send_pair(8'hFE, 8'hFE, 1'b0);
    send_pair(8'hFE, 8'hFE, 1'b0);
    send_pair(8'h7F, 8'h80, 1'b1);
    wait_drained();

    run_setting(32'd1, 32'd0);
    run_setting(32'd0, 32'd1);
    run_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_setting(32'd3, 32'd4);
    run_setting(32'd7, 32'd2);
    run_setting(32'd16, 32'd10);
    run_setting(BLOCK_SIZE_RST, BIG_THRESH_RST);
    run_setting($urandom_range(2, 12), $urandom_range(1, 20));

    if (ledger.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
